FILE: rtl/trop_pkg.sv
// Shared types, protocol constants and result-sequence tables for the telnet option parser.
`default_nettype none

package trop_pkg;

    // Telnet command bytes
    localparam logic [7:0] CMD_IAC  = 8'd255;
    localparam logic [7:0] CMD_DONT = 8'd254;
    localparam logic [7:0] CMD_DO   = 8'd253;
    localparam logic [7:0] CMD_WONT = 8'd252;
    localparam logic [7:0] CMD_WILL = 8'd251;
    localparam logic [7:0] CMD_SB   = 8'd250;
    localparam logic [7:0] CMD_SE   = 8'd240;

    // Option codes
    localparam logic [7:0] ECHO_OPTION  = 8'd1;
    localparam logic [7:0] SGA_OPTION   = 8'd3;
    localparam logic [7:0] TTYPE_OPTION = 8'd24;
    localparam logic [7:0] NAWS_OPTION  = 8'd31;
    localparam logic [7:0] TYPE_SEND = 8'd1;
    localparam logic [7:0] TYPE_IS   = 8'd0;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_NUL = 8'd0;

    // Window size limits and reset size
    localparam logic [9:0] WIDTH_MIN   = 10'd20;
    localparam logic [9:0] WIDTH_MAX   = 10'd1000;
    localparam logic [8:0] HEIGHT_MIN  = 9'd5;
    localparam logic [8:0] HEIGHT_MAX  = 9'd500;
    localparam logic [9:0] WIDTH_INIT  = 10'd80;
    localparam logic [8:0] HEIGHT_INIT = 9'd24;

    // Terminal names that mean no colour: dumb, unknown, net
    localparam int NUM_NAMES = 3;
    localparam logic [6:0] NAME_LEN [NUM_NAMES] = '{7'd4, 7'd7, 7'd3};

    // Request opcode on the input channel
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [2:0] {
        PH_DATA    = 3'd0,
        PH_IAC     = 3'd1,
        PH_OPT     = 3'd2,
        PH_SUB     = 3'd3,
        PH_SUB_IAC = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        LE_NONE = 2'd0,
        LE_CR   = 2'd1,
        LE_CRCR = 2'd2
    } line_end_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_SEND = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    // Shape of the result sequence caused by one request
    typedef enum logic [2:0] {
        BURST_NONE  = 3'd0,
        BURST_DATA1 = 3'd1,
        BURST_DATA2 = 3'd2,
        BURST_SEND3 = 3'd3,
        BURST_TTYPE = 3'd4,
        BURST_START = 3'd5
    } burst_t;

    // One queued result sequence with the flags as they stand after its request
    typedef struct packed {
        burst_t     burst;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       echo;
        logic       dumb;
        logic       known;
        logic [9:0] width;
        logic [8:0] height;
    } desc_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
    } elem_t;

    // Character k of terminal name w, compared against a lowercased byte
    function automatic logic name_char_ok(input logic [1:0] w, input logic [5:0] k,
                                          input logic [7:0] c);
        logic [7:0] ch;
        logic       ok;
        ch = 8'd0;
        ok = 1'b1;
        case (w)
            2'd0:
            begin
                case (k)
                    6'd0:    ch = "d";
                    6'd1:    ch = "u";
                    6'd2:    ch = "m";
                    6'd3:    ch = "b";
                    default: ok = 1'b0;
                endcase
            end
            2'd1:
            begin
                case (k)
                    6'd0:    ch = "u";
                    6'd1:    ch = "n";
                    6'd2:    ch = "k";
                    6'd3:    ch = "n";
                    6'd4:    ch = "o";
                    6'd5:    ch = "w";
                    6'd6:    ch = "n";
                    default: ok = 1'b0;
                endcase
            end
            2'd2:
            begin
                case (k)
                    6'd0:    ch = "n";
                    6'd1:    ch = "e";
                    6'd2:    ch = "t";
                    default: ok = 1'b0;
                endcase
            end
            default: ok = 1'b0;
        endcase
        return ok && (ch == c);
    endfunction

    // Result number idx of a queued sequence
    function automatic elem_t burst_elem(input desc_t d, input logic [3:0] idx);
        elem_t e;
        e.kind  = KIND_SEND;
        e.value = 8'd0;
        e.last  = 1'b0;
        case (d.burst)
            BURST_NONE:
            begin
                e.kind = KIND_NONE;
                e.last = 1'b1;
            end
            BURST_DATA1:
            begin
                e.kind  = KIND_DATA;
                e.value = d.b0;
                e.last  = 1'b1;
            end
            BURST_DATA2:
            begin
                e.kind  = KIND_DATA;
                e.value = (idx == 4'd0) ? CHAR_CR : d.b0;
                e.last  = (idx != 4'd0);
            end
            BURST_SEND3:
            begin
                case (idx)
                    4'd0:    e.value = CMD_IAC;
                    4'd1:    e.value = d.b0;
                    default: e.value = d.b1;
                endcase
                e.last = (idx == 4'd2);
            end
            BURST_TTYPE:
            begin
                case (idx)
                    4'd0:    e.value = CMD_IAC;
                    4'd1:    e.value = CMD_SB;
                    4'd2:    e.value = TTYPE_OPTION;
                    4'd3:    e.value = TYPE_SEND;
                    4'd4:    e.value = CMD_IAC;
                    default: e.value = CMD_SE;
                endcase
                e.last = (idx == 4'd5);
            end
            BURST_START:
            begin
                case (idx)
                    4'd1, 4'd4:          e.value = CMD_WILL;
                    4'd2:                e.value = ECHO_OPTION;
                    4'd5, 4'd8:          e.value = SGA_OPTION;
                    4'd7, 4'd10, 4'd13:  e.value = CMD_DO;
                    4'd11:               e.value = NAWS_OPTION;
                    4'd14:               e.value = TTYPE_OPTION;
                    default:             e.value = CMD_IAC;
                endcase
                e.last = (idx == 4'd14);
            end
            default:
            begin
                e.kind = KIND_NONE;
                e.last = 1'b1;
            end
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/trop_core.sv
// Parser state and next-state logic: decodes one request into a result sequence.
`default_nettype none

module trop_core
    import trop_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic       op,
    input  wire logic [7:0] byte_in,
    output desc_t           desc
);

    phase_t     phase_reg, phase_next;
    line_end_t  le_reg, le_next;
    logic [7:0] verb_reg, verb_next;
    logic [7:0] sub_opt_reg, sub_opt_next;
    logic       sub_seen_reg, sub_seen_next;
    logic [6:0] count_reg, count_next;
    logic       type_is_reg, type_is_next;
    logic [2:0] match_reg, match_next;
    logic       echo_reg, echo_next;
    logic       dumb_reg, dumb_next;
    logic       known_reg, known_next;
    logic [9:0] width_reg, width_next;
    logic [8:0] height_reg, height_next;

    // NAWS bytes; written before read, so no reset
    logic [7:0] size_reg [4];
    logic       size_we;

    logic       push_en;
    logic       finish_en;
    logic       pre_cr;
    logic       plain_out;
    line_end_t  le_mid;
    logic [7:0] lc;
    logic [5:0] name_k;
    logic [6:0] name_n;
    logic [7:0] fin_opt;
    logic       dumb_calc;
    logic [15:0] naws_w;
    logic [15:0] naws_h;
    logic [7:0] b;

    assign b      = byte_in;
    assign lc     = (b inside {[8'h41:8'h5A]}) ? (b + 8'd32) : b;
    assign name_k = count_reg[5:0] - 6'd1;
    assign name_n = count_reg - 7'd1;
    assign naws_w = {size_reg[0], size_reg[1]};
    assign naws_h = {size_reg[2], size_reg[3]};

    // Dumb-terminal verdict at the end of a TTYPE IS
    always_comb
    begin
        dumb_calc = (name_n == 7'd0);
        for (int i = 0; i < NUM_NAMES; i++)
        begin
            if (match_reg[i] && (name_n == NAME_LEN[i]))
            begin
                dumb_calc = 1'b1;
            end
        end
    end

    // Next state and result sequence
    always_comb
    begin
        phase_next    = phase_reg;
        le_next       = le_reg;
        verb_next     = verb_reg;
        sub_opt_next  = sub_opt_reg;
        sub_seen_next = sub_seen_reg;
        count_next    = count_reg;
        type_is_next  = type_is_reg;
        match_next    = match_reg;
        echo_next     = echo_reg;
        dumb_next     = dumb_reg;
        known_next    = known_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        size_we       = 1'b0;
        push_en       = 1'b0;
        finish_en     = 1'b0;
        pre_cr        = 1'b0;
        plain_out     = 1'b0;
        le_mid        = le_reg;
        fin_opt       = 8'd0;
        desc.burst    = BURST_NONE;
        desc.b0       = b;
        desc.b1       = b;

        if (op == OP_START)
        begin
            desc.burst = BURST_START;
        end
        else
        begin
            case (phase_reg)
                PH_IAC:
                begin
                    if (b == CMD_IAC)
                    begin
                        phase_next = PH_DATA;
                        desc.burst = BURST_DATA1;
                    end
                    else if (b == CMD_SB)
                    begin
                        phase_next    = PH_SUB;
                        sub_opt_next  = 8'd0;
                        sub_seen_next = 1'b0;
                        count_next    = 7'd0;
                        type_is_next  = 1'b0;
                        match_next    = 3'b111;
                    end
                    else if (b inside {CMD_WILL, CMD_WONT, CMD_DO, CMD_DONT})
                    begin
                        verb_next  = b;
                        phase_next = PH_OPT;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_OPT:
                begin
                    phase_next = PH_DATA;
                    case (verb_reg)
                        CMD_DO:
                        begin
                            if (b == ECHO_OPTION)
                            begin
                                echo_next = 1'b1;
                            end
                            else if (b != SGA_OPTION)
                            begin
                                desc.burst = BURST_SEND3;
                                desc.b0    = CMD_WONT;
                            end
                        end
                        CMD_DONT:
                        begin
                            if (b == ECHO_OPTION)
                            begin
                                echo_next = 1'b0;
                            end
                            desc.burst = BURST_SEND3;
                            desc.b0    = CMD_WONT;
                        end
                        CMD_WILL:
                        begin
                            if (b == TTYPE_OPTION)
                            begin
                                desc.burst = BURST_TTYPE;
                            end
                            else if (b != SGA_OPTION && b != NAWS_OPTION)
                            begin
                                desc.burst = BURST_SEND3;
                                desc.b0    = CMD_DONT;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                PH_SUB:
                begin
                    if (b == CMD_IAC)
                    begin
                        phase_next = PH_SUB_IAC;
                    end
                    else if (!sub_seen_reg)
                    begin
                        sub_opt_next  = b;
                        sub_seen_next = 1'b1;
                    end
                    else
                    begin
                        push_en = 1'b1;
                    end
                end
                PH_SUB_IAC:
                begin
                    if (b == CMD_SE)
                    begin
                        phase_next = PH_DATA;
                        finish_en  = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_SUB;
                        push_en    = (b == CMD_IAC);
                    end
                end
                default:
                begin
                    phase_next = PH_DATA;
                    // second CR of CR CR is released unless LF or NUL follows
                    if (le_reg == LE_CRCR)
                    begin
                        if (b == CHAR_LF || b == CHAR_NUL)
                        begin
                            le_next = LE_NONE;
                        end
                        else
                        begin
                            pre_cr = 1'b1;
                            le_mid = LE_CR;
                        end
                    end
                    if (le_reg != LE_CRCR || pre_cr)
                    begin
                        if (b == CMD_IAC)
                        begin
                            phase_next = PH_IAC;
                            le_next    = le_mid;
                        end
                        else if (le_mid == LE_CR)
                        begin
                            le_next = LE_NONE;
                            if (b == CHAR_CR)
                            begin
                                le_next = LE_CRCR;
                            end
                            else if (b != CHAR_LF && b != CHAR_NUL)
                            begin
                                plain_out = 1'b1;
                            end
                        end
                        else
                        begin
                            plain_out = 1'b1;
                            if (b == CHAR_CR)
                            begin
                                le_next = LE_CR;
                            end
                        end
                    end
                    if (pre_cr && plain_out)
                    begin
                        desc.burst = BURST_DATA2;
                    end
                    else if (pre_cr)
                    begin
                        desc.burst = BURST_DATA1;
                        desc.b0    = CHAR_CR;
                    end
                    else if (plain_out)
                    begin
                        desc.burst = BURST_DATA1;
                    end
                end
            endcase

            // Subnegotiation payload byte
            if (push_en && !count_reg[6])
            begin
                count_next = count_reg + 7'd1;
                size_we    = (count_reg < 7'd4);
                if (count_reg == 7'd0)
                begin
                    type_is_next = (b == TYPE_IS);
                end
                else
                begin
                    for (int i = 0; i < NUM_NAMES; i++)
                    begin
                        if (!name_char_ok(2'(i), name_k, lc))
                        begin
                            match_next[i] = 1'b0;
                        end
                    end
                end
            end

            // End of subnegotiation
            if (finish_en)
            begin
                fin_opt = sub_seen_reg ? sub_opt_reg : 8'd0;
                if (fin_opt == TTYPE_OPTION && count_reg != 7'd0 && type_is_reg)
                begin
                    dumb_next = dumb_calc;
                end
                if (fin_opt == NAWS_OPTION && count_reg >= 7'd4 &&
                    naws_w != 16'd0 && naws_h != 16'd0)
                begin
                    known_next = 1'b1;
                    if (naws_w < 16'(WIDTH_MIN))
                    begin
                        width_next = WIDTH_MIN;
                    end
                    else if (naws_w > 16'(WIDTH_MAX))
                    begin
                        width_next = WIDTH_MAX;
                    end
                    else
                    begin
                        width_next = naws_w[9:0];
                    end
                    if (naws_h < 16'(HEIGHT_MIN))
                    begin
                        height_next = HEIGHT_MIN;
                    end
                    else if (naws_h > 16'(HEIGHT_MAX))
                    begin
                        height_next = HEIGHT_MAX;
                    end
                    else
                    begin
                        height_next = naws_h[8:0];
                    end
                end
            end
        end

        desc.echo   = echo_next;
        desc.dumb   = dumb_next;
        desc.known  = known_next;
        desc.width  = width_next;
        desc.height = height_next;
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DATA;
            le_reg       <= LE_NONE;
            verb_reg     <= 8'd0;
            sub_opt_reg  <= 8'd0;
            sub_seen_reg <= 1'b0;
            count_reg    <= 7'd0;
            type_is_reg  <= 1'b0;
            match_reg    <= 3'b111;
            echo_reg     <= 1'b0;
            dumb_reg     <= 1'b0;
            known_reg    <= 1'b0;
            width_reg    <= WIDTH_INIT;
            height_reg   <= HEIGHT_INIT;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            le_reg       <= le_next;
            verb_reg     <= verb_next;
            sub_opt_reg  <= sub_opt_next;
            sub_seen_reg <= sub_seen_next;
            count_reg    <= count_next;
            type_is_reg  <= type_is_next;
            match_reg    <= match_next;
            echo_reg     <= echo_next;
            dumb_reg     <= dumb_next;
            known_reg    <= known_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
        end
    end

    // NAWS byte store
    always_ff @(posedge clk)
    begin
        if (accept && size_we)
        begin
            size_reg[count_reg[1:0]] <= b;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/telnet_receive_option_parser.sv
// Top level of the telnet receive option parser: parser core, result queue and output.
`default_nettype none

// Takes one request per cycle unless stalled: a received byte (op 0) or a start
// command (op 1). Each request yields 1 to 15 results, one per cycle on the
// output channel unless stalled; the last one carries last = 1, and every result
// shows the flags and window size as they stand after its request. A one-result
// request sustains one request per cycle; one with more results holds the output
// until its last one is taken (3 for an option reply, 6 for a terminal-type
// query, 15 for the start offers). A two-entry result queue sits between parser
// and output, so up to two parsed requests can wait on the output; in_stall rises
// only while both entries are full. No clearing pass is needed after reset.
module telnet_receive_option_parser
    import trop_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       op,
    input  wire logic [7:0] byte_in,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      value,
    output logic            last,
    output logic            echo_on,
    output logic            dumb_terminal,
    output logic            window_size_known,
    output logic [9:0]      window_width,
    output logic [8:0]      window_height
);

    desc_t      new_desc;
    desc_t      head_reg;
    desc_t      tail_reg;
    logic       head_valid_reg, head_valid_next;
    logic       tail_valid_reg, tail_valid_next;
    logic [3:0] idx_reg, idx_next;
    logic       accept;
    logic       take;
    logic       pop;
    logic       head_load_new;
    logic       head_load_tail;
    logic       tail_load_new;
    elem_t      el;

    assign in_stall = tail_valid_reg;
    assign accept   = in_valid && !tail_valid_reg;

    trop_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .op      (op),
        .byte_in (byte_in),
        .desc    (new_desc)
    );

    // Current result of the head sequence
    assign el   = burst_elem(head_reg, idx_reg);
    assign take = head_valid_reg && !out_stall;
    assign pop  = take && el.last;

    // Queue control
    always_comb
    begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_load_new   = 1'b0;
        head_load_tail  = 1'b0;
        tail_load_new   = 1'b0;
        idx_next        = idx_reg;
        if (pop)
        begin
            idx_next = 4'd0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 4'd1;
        end

        if (pop)
        begin
            if (tail_valid_reg)
            begin
                head_load_tail  = 1'b1;
                head_valid_next = 1'b1;
                tail_valid_next = 1'b0;
            end
            else
            begin
                head_load_new   = accept;
                head_valid_next = accept;
            end
        end
        else if (!head_valid_reg)
        begin
            head_load_new   = accept;
            head_valid_next = accept;
        end
        else if (accept)
        begin
            tail_load_new   = 1'b1;
            tail_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
            idx_reg        <= 4'd0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
            idx_reg        <= idx_next;
        end
    end

    // Queue payload
    always_ff @(posedge clk)
    begin
        if (head_load_new)
        begin
            head_reg <= new_desc;
        end
        else if (head_load_tail)
        begin
            head_reg <= tail_reg;
        end
        if (tail_load_new)
        begin
            tail_reg <= new_desc;
        end
    end

    // Output channel
    assign out_valid         = head_valid_reg;
    assign kind              = el.kind;
    assign value             = el.value;
    assign last              = el.last;
    assign echo_on           = head_reg.echo;
    assign dumb_terminal     = head_reg.dumb;
    assign window_size_known = head_reg.known;
    assign window_width      = head_reg.width;
    assign window_height     = head_reg.height;

endmodule

`default_nettype wire

FILE: rtl/trop_checker.sv
// Port-level assertions for the telnet receive option parser and their bind.
`default_nettype none

module trop_checker
    import trop_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] kind,
    input wire logic [7:0] value,
    input wire logic       last,
    input wire logic       echo_on,
    input wire logic       dumb_terminal,
    input wire logic       window_size_known,
    input wire logic [9:0] window_width,
    input wire logic [8:0] window_height
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // An empty result is a single zero-valued result
    a_none_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_NONE |-> value == 8'd0 && last)
        else $error("empty result not single or not zero");

    // Only defined kinds appear
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind == KIND_DATA || kind == KIND_SEND || kind == KIND_NONE)
        else $error("undefined result kind");

    // Window size always within its clamp range
    a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> window_width >= WIDTH_MIN && window_width <= WIDTH_MAX &&
                      window_height >= HEIGHT_MIN && window_height <= HEIGHT_MAX)
        else $error("window size out of range");

    // A sequence continues in the next cycle with the same flags
    a_seq_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && echo_on == $past(echo_on) &&
            dumb_terminal == $past(dumb_terminal) &&
            window_size_known == $past(window_size_known))
        else $error("result sequence broken or flags changed mid-sequence");

endmodule

bind telnet_receive_option_parser trop_checker u_trop_checker (.*);

`default_nettype wire

FILE: test/telnet_receive_option_parser_tb.sv
// Testbench for the telnet receive option parser: directed and random byte streams vs. a predictor.
`timescale 1ns / 100ps

module telnet_receive_option_parser_tb;
    import trop_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_CYCLES = 24;
    localparam int SUB_CAP      = 64;
    localparam logic [7:0] CMD_NOP = 8'd241;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
    } reply_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] value;
        logic       last;
        logic       echo;
        logic       dumb;
        logic       known;
        logic [9:0] width;
        logic [8:0] height;
    } result_t;

    logic       clk;
    logic       rst_n    = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       op       = OP_BYTE;
    logic [7:0] byte_in  = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;
    logic       echo_on;
    logic       dumb_terminal;
    logic       window_size_known;
    logic [9:0] window_width;
    logic [8:0] window_height;

    // Parser state as predicted
    phase_t     rx_phase       = PH_DATA;
    line_end_t  cr_state       = LE_NONE;
    logic [7:0] verb_hold      = 8'd0;
    logic [7:0] sb_option      = 8'd0;
    logic       sb_option_seen = 1'b0;
    logic [6:0] sb_count       = 7'd0;
    logic [7:0] naws_bytes [4];
    logic       type_is_m      = 1'b0;
    logic [2:0] name_match     = 3'b111;
    logic       echo_m         = 1'b0;
    logic       dumb_m         = 1'b0;
    logic       known_m        = 1'b0;
    logic [9:0] width_m        = WIDTH_INIT;
    logic [8:0] height_m       = HEIGHT_INIT;
    string      plain_names [3] = '{"dumb", "unknown", "net"};

    reply_t     step_replies [$];
    result_t    awaited_results [$];
    logic [7:0] name_buf [$];
    int         mismatch_count = 0;
    int         requests_sent  = 0;
    bit         idle_on        = 1'b1;

    telnet_receive_option_parser dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .op                (op),
        .byte_in           (byte_in),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .kind              (kind),
        .value             (value),
        .last              (last),
        .echo_on           (echo_on),
        .dumb_terminal     (dumb_terminal),
        .window_size_known (window_size_known),
        .window_width      (window_width),
        .window_height     (window_height)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic void emit(kind_t k, logic [7:0] v);
        reply_t r;
        r.kind  = k;
        r.value = v;
        step_replies.insert(step_replies.size(), r);
    endfunction

    function automatic void emit_cmd(logic [7:0] verb, logic [7:0] opt);
        emit(KIND_SEND, CMD_IAC);
        emit(KIND_SEND, verb);
        emit(KIND_SEND, opt);
    endfunction

    // Text path: CR LF and CR NUL fold into CR, a CR after a CR is held back
    function automatic void text_byte(logic [7:0] b);
        if (cr_state == LE_CR)
        begin
            cr_state = LE_NONE;
            if (b == CHAR_CR)
                cr_state = LE_CRCR;
            else if (b != CHAR_LF && b != CHAR_NUL)
                emit(KIND_DATA, b);
        end
        else if (b == CHAR_CR)
        begin
            emit(KIND_DATA, CHAR_CR);
            cr_state = LE_CR;
        end
        else
            emit(KIND_DATA, b);
    endfunction

    // Subnegotiation payload: keep size bytes, track terminal-name matches
    function automatic void collect_payload(logic [7:0] b);
        int         idx;
        logic [7:0] lc;
        idx = sb_count;
        if (idx >= SUB_CAP)
            return;
        sb_count = sb_count + 7'd1;
        if (idx < 4)
            naws_bytes[idx] = b;
        if (idx == 0)
        begin
            type_is_m = (b == TYPE_IS);
            return;
        end
        lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        for (int i = 0; i < 3; i++)
            if (idx - 1 >= plain_names[i].len() || plain_names[i][idx - 1] != lc)
                name_match[i] = 1'b0;
    endfunction

    function automatic void close_subneg();
        logic [7:0]  opt;
        int          n;
        logic        d;
        logic [15:0] w;
        logic [15:0] h;
        opt = sb_option_seen ? sb_option : 8'd0;
        if (opt == TTYPE_OPTION && sb_count >= 1 && type_is_m)
        begin
            n = sb_count - 1;
            d = (n == 0);
            for (int i = 0; i < 3; i++)
                if (name_match[i] && n == plain_names[i].len())
                    d = 1'b1;
            dumb_m = d;
        end
        if (opt == NAWS_OPTION && sb_count >= 4)
        begin
            w = {naws_bytes[0], naws_bytes[1]};
            h = {naws_bytes[2], naws_bytes[3]};
            if (w != 16'd0 && h != 16'd0)
            begin
                width_m  = (w < WIDTH_MIN) ? WIDTH_MIN : (w > WIDTH_MAX) ? WIDTH_MAX : w[9:0];
                height_m = (h < HEIGHT_MIN) ? HEIGHT_MIN : (h > HEIGHT_MAX) ? HEIGHT_MAX : h[8:0];
                known_m  = 1'b1;
            end
        end
    endfunction

    // Replies to DO / DONT / WILL; WONT is accepted silently
    function automatic void answer_request(logic [7:0] verb, logic [7:0] opt);
        if (verb == CMD_DO)
        begin
            if (opt == ECHO_OPTION)
                echo_m = 1'b1;
            else if (opt != SGA_OPTION)
                emit_cmd(CMD_WONT, opt);
        end
        else if (verb == CMD_DONT)
        begin
            if (opt == ECHO_OPTION)
                echo_m = 1'b0;
            emit_cmd(CMD_WONT, opt);
        end
        else if (verb == CMD_WILL)
        begin
            if (opt == TTYPE_OPTION)
            begin
                emit_cmd(CMD_SB, TTYPE_OPTION);
                emit(KIND_SEND, TYPE_SEND);
                emit(KIND_SEND, CMD_IAC);
                emit(KIND_SEND, CMD_SE);
            end
            else if (opt != SGA_OPTION && opt != NAWS_OPTION)
                emit_cmd(CMD_DONT, opt);
        end
    endfunction

    function automatic void parse_byte(logic [7:0] b);
        case (rx_phase)
            PH_IAC:
            begin
                if (b == CMD_IAC)
                begin
                    rx_phase = PH_DATA;
                    emit(KIND_DATA, CMD_IAC);
                end
                else if (b == CMD_SB)
                begin
                    rx_phase       = PH_SUB;
                    sb_option      = 8'd0;
                    sb_option_seen = 1'b0;
                    sb_count       = 7'd0;
                    type_is_m      = 1'b0;
                    name_match     = 3'b111;
                end
                else if (b == CMD_WILL || b == CMD_WONT || b == CMD_DO || b == CMD_DONT)
                begin
                    verb_hold = b;
                    rx_phase  = PH_OPT;
                end
                else
                    rx_phase = PH_DATA;
            end
            PH_OPT:
            begin
                rx_phase = PH_DATA;
                answer_request(verb_hold, b);
            end
            PH_SUB:
            begin
                if (b == CMD_IAC)
                    rx_phase = PH_SUB_IAC;
                else if (!sb_option_seen)
                begin
                    sb_option      = b;
                    sb_option_seen = 1'b1;
                end
                else
                    collect_payload(b);
            end
            PH_SUB_IAC:
            begin
                if (b == CMD_SE)
                begin
                    rx_phase = PH_DATA;
                    close_subneg();
                end
                else
                begin
                    rx_phase = PH_SUB;
                    if (b == CMD_IAC)
                        collect_payload(b);
                end
            end
            default:
            begin
                rx_phase = PH_DATA;
                // CR CR: drop on LF / NUL, else release the second CR first
                if (cr_state == LE_CRCR)
                begin
                    if (b == CHAR_LF || b == CHAR_NUL)
                    begin
                        cr_state = LE_NONE;
                        return;
                    end
                    emit(KIND_DATA, CHAR_CR);
                    cr_state = LE_CR;
                end
                if (b == CMD_IAC)
                    rx_phase = PH_IAC;
                else
                    text_byte(b);
            end
        endcase
    endfunction

    // Expected results of one accepted request, flags as they stand after it
    function automatic void telnet_step(logic o, logic [7:0] b);
        result_t r;
        step_replies.delete();
        if (o == OP_START)
        begin
            emit_cmd(CMD_WILL, ECHO_OPTION);
            emit_cmd(CMD_WILL, SGA_OPTION);
            emit_cmd(CMD_DO, SGA_OPTION);
            emit_cmd(CMD_DO, NAWS_OPTION);
            emit_cmd(CMD_DO, TTYPE_OPTION);
        end
        else
            parse_byte(b);
        if (step_replies.size() == 0)
            emit(KIND_NONE, 8'd0);
        foreach (step_replies[i])
        begin
            r.kind   = step_replies[i].kind;
            r.value  = step_replies[i].value;
            r.last   = (i == step_replies.size() - 1);
            r.echo   = echo_m;
            r.dumb   = dumb_m;
            r.known  = known_m;
            r.width  = width_m;
            r.height = height_m;
            awaited_results.insert(awaited_results.size(), r);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_request(logic o, logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        byte_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        telnet_step(o, b);
        requests_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_request(OP_BYTE, b);
    endtask

    task automatic send_start();
        send_request(OP_START, 8'($urandom_range(0, 255)));
    endtask

    // Payload byte, doubled when it is IAC
    task automatic send_escaped(logic [7:0] b);
        if (b == CMD_IAC)
            send_byte(CMD_IAC);
        send_byte(b);
    endtask

    task automatic send_option(logic [7:0] verb, logic [7:0] opt);
        send_byte(CMD_IAC);
        send_byte(verb);
        send_byte(opt);
    endtask

    task automatic send_naws(logic [15:0] w, logic [15:0] h);
        send_byte(CMD_IAC);
        send_byte(CMD_SB);
        send_byte(NAWS_OPTION);
        send_escaped(w[15:8]);
        send_escaped(w[7:0]);
        send_escaped(h[15:8]);
        send_escaped(h[7:0]);
        send_byte(CMD_IAC);
        send_byte(CMD_SE);
    endtask

    task automatic send_ttype(bit with_is);
        send_byte(CMD_IAC);
        send_byte(CMD_SB);
        send_byte(TTYPE_OPTION);
        if (with_is)
            send_byte(TYPE_IS);
        foreach (name_buf[i])
            send_escaped(name_buf[i]);
        send_byte(CMD_IAC);
        send_byte(CMD_SE);
    endtask

    function automatic void load_name(string s, bit mix_case);
        logic [7:0] c;
        name_buf.delete();
        for (int i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mix_case && c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                c = c - 8'd32;
            name_buf.insert(name_buf.size(), c);
        end
    endfunction

    function automatic logic [15:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 16'd0;
        if (r < 6)
            return 16'($urandom_range(1, 25));
        if (r < 15)
            return 16'($urandom_range(26, 600));
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic test_data_path();
        send_byte(8'h00);
        send_byte(8'hFE);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'h7F);
        send_byte(CMD_IAC);
        send_byte(CMD_IAC);
        send_start();
    endtask

    task automatic test_line_endings();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(CHAR_CR);
        send_byte(CHAR_NUL);
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // CR CR then a plain byte: second CR comes out first
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte("a");
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // pending CR survives an escaped 255 and an option request
        send_byte(CHAR_CR);
        send_byte(CMD_IAC);
        send_byte(CMD_IAC);
        send_option(CMD_DO, ECHO_OPTION);
        send_byte(CHAR_LF);
    endtask

    task automatic test_option_replies();
        logic [7:0] verbs [4] = '{CMD_DO, CMD_DONT, CMD_WILL, CMD_WONT};
        logic [7:0] opts [5]  = '{ECHO_OPTION, SGA_OPTION, TTYPE_OPTION, NAWS_OPTION, 8'd42};
        foreach (verbs[v])
            foreach (opts[o])
                send_option(verbs[v], opts[o]);
        send_option(CMD_DO, ECHO_OPTION);
        send_byte(CMD_IAC);
        send_byte(CMD_NOP);
        // start command between verb and option
        send_byte(CMD_IAC);
        send_byte(CMD_DONT);
        send_start();
        send_byte(ECHO_OPTION);
    endtask

    task automatic test_window_size();
        send_naws(16'd132, 16'd50);
        send_naws(16'd5, 16'd2);
        send_naws(16'hFFFF, 16'h03FF);
        send_naws(16'd0, 16'd40);
        send_naws(16'd90, 16'd0);
        // short payload is ignored
        send_byte(CMD_IAC);
        send_byte(CMD_SB);
        send_byte(NAWS_OPTION);
        send_byte(8'd0);
        send_byte(8'd77);
        send_byte(CMD_IAC);
        send_byte(CMD_SE);
    endtask

    task automatic test_terminal_type();
        string names [7] = '{"DUMB", "xterm", "", "vt100", "Net", "unknow", "UnKnown"};
        foreach (names[i])
        begin
            load_name(names[i], 1'b0);
            send_ttype(1'b1);
        end
        load_name("xterm", 1'b0);
        send_ttype(1'b0);
    endtask

    task automatic test_subneg_corners();
        // escaped 255 ahead of the option byte counts as payload
        send_byte(CMD_IAC);
        send_byte(CMD_SB);
        send_byte(CMD_IAC);
        send_byte(CMD_IAC);
        send_byte(NAWS_OPTION);
        send_byte(8'd0);
        send_byte(8'd100);
        send_byte(8'd0);
        send_byte(CMD_IAC);
        send_byte(CMD_SE);
        // stray command inside SB is dropped; the byte after it counts as payload
        send_byte(CMD_IAC);
        send_byte(CMD_SB);
        send_byte(NAWS_OPTION);
        send_byte(8'd0);
        send_byte(CMD_IAC);
        send_byte(CMD_DO);
        send_byte(8'd90);
        send_start();
        send_byte(8'd0);
        send_byte(8'd30);
        send_byte(CMD_IAC);
        send_byte(CMD_SE);
        // name past the payload cap
        name_buf.delete();
        repeat (70)
            name_buf.insert(name_buf.size(), 8'($urandom_range(97, 122)));
        send_ttype(1'b1);
        load_name("dumb", 1'b1);
        send_ttype(1'b1);
        // subnegotiation while a CR is pending
        send_byte(CHAR_CR);
        send_naws(16'd200, 16'd60);
        send_byte(CHAR_NUL);
    endtask

    task automatic test_random_traffic();
        string      words [6] = '{"dumb", "unknown", "net", "xterm", "netx", "unknow"};
        logic [7:0] verbs [4] = '{CMD_DO, CMD_DONT, CMD_WILL, CMD_WONT};
        logic [7:0] opts [4]  = '{ECHO_OPTION, SGA_OPTION, TTYPE_OPTION, NAWS_OPTION};
        int         stop_at;
        int         r;
        int         k;
        stop_at = requests_sent + RANDOM_ITEMS;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(0, 29) == 0)
                idle_on = !idle_on;
            r = $urandom_range(0, 99);
            if (r < 25)
            begin
                k = $urandom_range(0, 9);
                if (k < 2)
                    send_byte(CHAR_CR);
                else if (k == 2)
                    send_byte(CHAR_LF);
                else if (k == 3)
                    send_byte(CHAR_NUL);
                else
                    send_byte(8'($urandom_range(0, 254)));
            end
            else if (r < 32)
            begin
                send_byte(CMD_IAC);
                send_byte(CMD_IAC);
            end
            else if (r < 54)
            begin
                if ($urandom_range(0, 9) < 7)
                    send_option(verbs[$urandom_range(0, 3)], opts[$urandom_range(0, 3)]);
                else
                    send_option(verbs[$urandom_range(0, 3)], 8'($urandom_range(0, 255)));
            end
            else if (r < 67)
                send_naws(pick_dim(), pick_dim());
            else if (r < 80)
            begin
                k = $urandom_range(0, 9);
                if (k < 6)
                    load_name(words[$urandom_range(0, 5)], 1'b1);
                else
                begin
                    name_buf.delete();
                    repeat ((k == 9) ? $urandom_range(60, 70) : $urandom_range(0, 8))
                        name_buf.insert(name_buf.size(), 8'($urandom_range(0, 255)));
                end
                send_ttype($urandom_range(0, 9) != 0);
            end
            else if (r < 85)
                send_start();
            else if (r < 93)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                // broken subnegotiation: opened, never closed here
                send_byte(CMD_IAC);
                send_byte(CMD_SB);
                repeat ($urandom_range(0, 3))
                    send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver stall pattern
    initial
    begin : receiver_stall
        int hold;
        int r;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (!idle_on)
                out_stall <= 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    out_stall <= 1'b0;
                else if (r < 96)
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(0, 2);
                end
                else
                begin
                    out_stall <= 1'b1;
                    hold = $urandom_range(8, 24);
                end
            end
        end
    end

    function automatic void check_field(string field, int expected, int actual);
        if (expected != actual)
        begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            mismatch_count++;
        end
    endfunction

    // Compare every accepted result with the oldest awaited one
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d", kind, value);
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("kind", int'(want.kind), kind);
                check_field("value", want.value, value);
                check_field("last", want.last, last);
                check_field("echo_on", want.echo, echo_on);
                check_field("dumb_terminal", want.dumb, dumb_terminal);
                check_field("window_size_known", want.known, window_size_known);
                check_field("window_width", want.width, window_width);
                check_field("window_height", want.height, window_height);
            end
        end
    end

    initial
    begin : watchdog
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("telnet_receive_option_parser_tb: done, errors");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_data_path();
        test_line_endings();
        test_option_replies();
        test_window_size();
        test_terminal_type();
        test_subneg_corners();
        test_random_traffic();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("telnet_receive_option_parser_tb: done, clean");
        else
            $display("telnet_receive_option_parser_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/trop_pkg.sv
rtl/trop_core.sv
rtl/telnet_receive_option_parser.sv
rtl/trop_checker.sv
test/telnet_receive_option_parser_tb.sv
